@@ rtl/ecf_pkg.sv @@
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared types and constants of the escape command capture filter: register
// indexes, result kinds, line-end codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package ecf_pkg;

    localparam int CMD_DEPTH_DEF = 64;

    localparam logic [1:0] CFG_ESC   = 2'd0;
    localparam logic [1:0] CFG_START = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    localparam logic [7:0] ESC_RESET   = 8'd27;
    localparam logic [7:0] START_RESET = 8'd123;
    localparam logic [7:0] END_RESET   = 8'd125;

    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;

    localparam logic [1:0] KIND_PASS  = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // source of the byte loaded into the output register
    typedef enum logic [2:0] {
        SEL_PASS  = 3'd0,
        SEL_ESC   = 3'd1,
        SEL_HELD  = 3'd2,
        SEL_MEM   = 3'd3,
        SEL_EMPTY = 3'd4
    } t_out_sel;

    typedef struct packed {
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
        logic     hold_byte;
        logic     store_write;
        logic     set_ovf;
        logic     clear_cap;
        logic     rd_start;
        logic     rd_next;
    } t_cmd;

    typedef struct packed {
        logic is_esc;
        logic is_start;
        logic is_end;
        logic is_eol;
        logic len_zero;
        logic len_full;
        logic replay_last;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/ecf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ecf_ctrl
// Mode state machine: decodes each accepted byte against the status from the
// datapath and issues load, store and replay commands.
// ----------------------------------------------------------------------------
module ecf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ecf_pkg::t_stat i_stat,
    output ecf_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ESC    = 5'b00010,
        S_CAP    = 5'b00100,
        S_PAIR   = 5'b01000,
        S_REPLAY = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = i_stat.out_free &&
                        (r_state == S_IDLE || r_state == S_ESC || r_state == S_CAP);
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_sel = ecf_pkg::SEL_PASS;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_stat.is_esc) begin
                        n_state = S_ESC;
                    end else begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_last = 1'b1;
                    end
                end
            end
            S_ESC: begin
                if (w_acc) begin
                    priority if (i_stat.is_eol) begin
                        o_cmd.clear_cap = 1'b1;
                        n_state = S_IDLE;
                    end else if (i_stat.is_start) begin
                        o_cmd.clear_cap = 1'b1;
                        n_state = S_CAP;
                    end else begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_sel   = ecf_pkg::SEL_ESC;
                        o_cmd.hold_byte = 1'b1;
                        n_state = S_PAIR;
                    end
                end
            end
            S_PAIR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = ecf_pkg::SEL_HELD;
                    o_cmd.out_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CAP: begin
                if (w_acc) begin
                    priority if (i_stat.is_eol) begin
                        o_cmd.clear_cap = 1'b1;
                        n_state = S_IDLE;
                    end else if (i_stat.is_end) begin
                        if (i_stat.len_zero) begin
                            o_cmd.out_load  = 1'b1;
                            o_cmd.out_sel   = ecf_pkg::SEL_EMPTY;
                            o_cmd.out_last  = 1'b1;
                            o_cmd.clear_cap = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_state = S_REPLAY;
                        end
                    end else if (!i_stat.len_full) begin
                        o_cmd.store_write = 1'b1;
                    end else begin
                        o_cmd.set_ovf = 1'b1;
                    end
                end
            end
            S_REPLAY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = ecf_pkg::SEL_MEM;
                    o_cmd.out_last = i_stat.replay_last;
                    if (i_stat.replay_last) begin
                        o_cmd.clear_cap = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/ecf_dp.sv @@
// ----------------------------------------------------------------------------
// ecf_dp
// Datapath: code registers, byte compares, command store with registered
// read, length and overflow tracking, and the output register.
// ----------------------------------------------------------------------------
module ecf_dp #(
    parameter int CMD_DEPTH = ecf_pkg::CMD_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_data_byte,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    input  ecf_pkg::t_cmd  i_cmd,
    output ecf_pkg::t_stat o_stat,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic [1:0]     o_out_kind,
    output logic           o_is_last,
    output logic           o_truncated
);

    localparam int LW = $clog2(CMD_DEPTH + 1);
    localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

    logic [7:0]    r_esc;
    logic [7:0]    r_start;
    logic [7:0]    r_end;
    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic [LW-1:0] r_idx;
    logic [LW-1:0] w_idx_inc;
    logic [7:0]    r_held;
    logic [7:0]    r_rd_data;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    r_store [CMD_DEPTH];
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [1:0]    r_out_kind;
    logic          r_is_last;
    logic          r_truncated;

    assign w_idx_inc = r_idx + LW'(1);
    assign w_rd_addr = i_cmd.rd_start ? '0 : w_idx_inc[AW-1:0];

    always_comb begin
        o_stat.is_esc      = (i_data_byte == r_esc);
        o_stat.is_start    = (i_data_byte == r_start);
        o_stat.is_end      = (i_data_byte == r_end);
        o_stat.is_eol      = (i_data_byte == ecf_pkg::CODE_CR) ||
                             (i_data_byte == ecf_pkg::CODE_LF);
        o_stat.len_zero    = (r_len == '0);
        o_stat.len_full    = (r_len == LW'(CMD_DEPTH));
        o_stat.replay_last = (w_idx_inc == r_len);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= ecf_pkg::ESC_RESET;
            r_start <= ecf_pkg::START_RESET;
            r_end   <= ecf_pkg::END_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ecf_pkg::CFG_ESC:   r_esc   <= i_cfg_data;
                ecf_pkg::CFG_START: r_start <= i_cfg_data;
                ecf_pkg::CFG_END:   r_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture length and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.clear_cap) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (i_cmd.store_write) begin
                r_len <= r_len + LW'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // command store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_write) begin
            r_store[r_len[AW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd_start || i_cmd.rd_next) begin
            r_rd_data <= r_store[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_idx <= w_idx_inc;
        end
        if (i_cmd.hold_byte) begin
            r_held <= i_data_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_is_last <= i_cmd.out_last;
            unique case (i_cmd.out_sel)
                ecf_pkg::SEL_PASS: begin
                    r_out_byte  <= i_data_byte;
                    r_out_kind  <= ecf_pkg::KIND_PASS;
                    r_truncated <= 1'b0;
                end
                ecf_pkg::SEL_ESC: begin
                    r_out_byte  <= r_esc;
                    r_out_kind  <= ecf_pkg::KIND_PASS;
                    r_truncated <= 1'b0;
                end
                ecf_pkg::SEL_HELD: begin
                    r_out_byte  <= r_held;
                    r_out_kind  <= ecf_pkg::KIND_PASS;
                    r_truncated <= 1'b0;
                end
                ecf_pkg::SEL_MEM: begin
                    r_out_byte  <= r_rd_data;
                    r_out_kind  <= ecf_pkg::KIND_CMD;
                    r_truncated <= r_ovf;
                end
                ecf_pkg::SEL_EMPTY: begin
                    r_out_byte  <= '0;
                    r_out_kind  <= ecf_pkg::KIND_EMPTY;
                    r_truncated <= r_ovf;
                end
                default: begin
                    r_out_byte  <= i_data_byte;
                    r_out_kind  <= ecf_pkg::KIND_PASS;
                    r_truncated <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_kind  = r_out_kind;
    assign o_is_last   = r_is_last;
    assign o_truncated = r_truncated;

endmodule

@@ rtl/escape_command_capture_filter_unit.sv @@
// ----------------------------------------------------------------------------
// escape_command_capture_filter_unit
// A result is loaded into the output register as its beat is accepted; the
// first byte of a command replay first passes the registered store read.
// Input is taken one byte per cycle while the output register is free, but
// not during an escape pair or a replay from the store's single read port.
// Reset (synchronous, active low): idle mode, codes 27/123/125, store empty.
// ----------------------------------------------------------------------------
module escape_command_capture_filter_unit #(
    parameter int CMD_DEPTH = ecf_pkg::CMD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_is_last,
    output logic       o_truncated,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    ecf_pkg::t_cmd  w_cmd;
    ecf_pkg::t_stat w_stat;

    // code registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    ecf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ecf_dp #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_kind  (o_out_kind),
        .o_is_last   (o_is_last),
        .o_truncated (o_truncated)
    );

endmodule

@@ tb/tb_escape_command_capture_filter_unit.sv @@
// ----------------------------------------------------------------------------
// tb_escape_command_capture_filter_unit
// Self-checking bench for the escape command capture filter. A short table of
// directed console bytes runs first: pass-through, escape pairs, silent aborts,
// empty and replayed commands. A full and a truncated command, then random
// command sequences and noise follow under several code settings. Every accepted
// byte feeds a behavioral model; each output beat is compared to its expectation.
// ----------------------------------------------------------------------------
module tb_escape_command_capture_filter_unit;

    localparam int          DEPTH      = ecf_pkg::CMD_DEPTH_DEF;
    localparam int          LIMIT      = 4000000;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        M_IDLE    = 2'd0,
        M_ESC     = 2'd1,
        M_CAPTURE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
        logic       trunc;
    } t_res;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;    // expectation typed in below
        logic       has_res;  // typed row gives one beat
        t_res       res;
    } t_row;

    localparam t_res NO_RES = '0;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic [1:0] o_out_kind;
    logic       o_is_last;
    logic       o_truncated;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    // filter model state
    t_mode      flt_mode;
    logic [7:0] cmd_mem [DEPTH];
    int         cmd_len;
    logic       cmd_ovf;
    logic [7:0] esc_reg;
    logic [7:0] start_reg;
    logic [7:0] end_reg;

    t_res       step_beats [$];
    t_res       out_beats_q [$];

    logic       row_typed;
    logic       row_has_res;
    t_res       row_res;

    bit         quiet;
    int         stall_left;
    int         err_cnt;
    int         sent_cnt;
    int         cycles;

    // reset codes: esc 1B, start 7B, end 7D
    t_row dir_tbl [25] = '{
        '{8'h41, 1'b1, 1'b1, '{8'h41, ecf_pkg::KIND_PASS, 1'b1, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, ecf_pkg::KIND_PASS, 1'b1, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, ecf_pkg::KIND_PASS, 1'b1, 1'b0}},
        '{8'h0D, 1'b1, 1'b1, '{8'h0D, ecf_pkg::KIND_PASS, 1'b1, 1'b0}},
        '{8'h1B, 1'b1, 1'b0, NO_RES},
        '{8'h0A, 1'b1, 1'b0, NO_RES},
        '{8'h1B, 1'b1, 1'b0, NO_RES},
        '{8'h41, 1'b0, 1'b0, NO_RES},
        '{8'h1B, 1'b1, 1'b0, NO_RES},
        '{8'h1B, 1'b0, 1'b0, NO_RES},
        '{8'h1B, 1'b1, 1'b0, NO_RES},
        '{8'h7B, 1'b1, 1'b0, NO_RES},
        '{8'h7D, 1'b1, 1'b1, '{8'h00, ecf_pkg::KIND_EMPTY, 1'b1, 1'b0}},
        '{8'h1B, 1'b1, 1'b0, NO_RES},
        '{8'h7B, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b0, NO_RES},
        '{8'h7B, 1'b1, 1'b0, NO_RES},
        '{8'h0D, 1'b1, 1'b0, NO_RES},
        '{8'h1B, 1'b1, 1'b0, NO_RES},
        '{8'h7B, 1'b1, 1'b0, NO_RES},
        '{8'h1B, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b0, NO_RES},
        '{8'h7D, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, ecf_pkg::KIND_PASS, 1'b1, 1'b0}}
    };

    logic [7:0] ph_esc   [6] = '{ecf_pkg::ESC_RESET, 8'h00, 8'hFF, ecf_pkg::CODE_CR,
                                 8'h00, ecf_pkg::ESC_RESET};
    logic [7:0] ph_start [6] = '{ecf_pkg::START_RESET, 8'h00, 8'hFF, ecf_pkg::CODE_LF,
                                 8'h00, ecf_pkg::START_RESET};
    logic [7:0] ph_end   [6] = '{ecf_pkg::END_RESET, 8'h00, 8'hFF, ecf_pkg::CODE_CR,
                                 8'h00, ecf_pkg::END_RESET};
    int         ph_items [6] = '{80, 30, 30, 30, 30, 30};

    escape_command_capture_filter_unit #(
        .CMD_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_out_kind (o_out_kind),
        .o_is_last  (o_is_last),
        .o_truncated(o_truncated),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void add_beat(input logic [7:0] data, input logic [1:0] kind,
                                     input logic last, input logic trunc);
        t_res r;
        r.data  = data;
        r.kind  = kind;
        r.last  = last;
        r.trunc = trunc;
        step_beats.push_back(r);
    endfunction

    function automatic void filter_predict(input logic [7:0] d);
        logic eol;
        int   k;
        eol = (d == ecf_pkg::CODE_CR) || (d == ecf_pkg::CODE_LF);
        case (flt_mode)
            M_IDLE: begin
                if (d == esc_reg) flt_mode = M_ESC;
                else add_beat(d, ecf_pkg::KIND_PASS, 1'b1, 1'b0);
            end
            M_ESC: begin
                if (eol) begin
                    flt_mode = M_IDLE;
                    cmd_len  = 0;
                    cmd_ovf  = 1'b0;
                end else if (d == start_reg) begin
                    flt_mode = M_CAPTURE;
                    cmd_len  = 0;
                    cmd_ovf  = 1'b0;
                end else begin
                    add_beat(esc_reg, ecf_pkg::KIND_PASS, 1'b0, 1'b0);
                    add_beat(d, ecf_pkg::KIND_PASS, 1'b1, 1'b0);
                    flt_mode = M_IDLE;
                end
            end
            M_CAPTURE: begin
                if (eol) begin
                    flt_mode = M_IDLE;
                    cmd_len  = 0;
                    cmd_ovf  = 1'b0;
                end else if (d == end_reg) begin
                    if (cmd_len == 0) add_beat(8'h00, ecf_pkg::KIND_EMPTY, 1'b1, cmd_ovf);
                    for (k = 0; k < cmd_len; k++)
                        add_beat(cmd_mem[k], ecf_pkg::KIND_CMD, k + 1 == cmd_len, cmd_ovf);
                    flt_mode = M_IDLE;
                    cmd_len  = 0;
                    cmd_ovf  = 1'b0;
                end else if (cmd_len < DEPTH) begin
                    cmd_mem[cmd_len] = d;
                    cmd_len++;
                end else begin
                    cmd_ovf = 1'b1;
                end
            end
            default: begin
                flt_mode = M_IDLE;
                add_beat(d, ecf_pkg::KIND_PASS, 1'b1, 1'b0);
            end
        endcase
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // command bytes that neither close nor abort the capture
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == ecf_pkg::CODE_CR || b == ecf_pkg::CODE_LF || b == end_reg)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic int cmd_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 92) return $urandom_range(9, DEPTH - 1);
        return $urandom_range(DEPTH, DEPTH + 8);
    endfunction

    // prediction and checking, both on the rising edge
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ecf_pkg::CFG_ESC:   esc_reg   = i_cfg_data;
                    ecf_pkg::CFG_START: start_reg = i_cfg_data;
                    ecf_pkg::CFG_END:   end_reg   = i_cfg_data;
                    default:   ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                step_beats.delete();
                filter_predict(i_data_byte);
                if (row_typed) begin
                    if (row_has_res) out_beats_q.push_back(row_res);
                end else begin
                    foreach (step_beats[k]) out_beats_q.push_back(step_beats[k]);
                end
            end
            if (o_out_valid && i_out_ready) begin
                got.data  = o_out_byte;
                got.kind  = o_out_kind;
                got.last  = o_is_last;
                got.trunc = o_truncated;
                if (out_beats_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output beat, expected none got %h", $time, got);
                end else begin
                    want = out_beats_q.pop_front();
                    if (got.data !== want.data) begin
                        err_cnt++;
                        $display("%0t: out_byte expected %h got %h", $time, want.data, got.data);
                    end
                    if (got.kind !== want.kind) begin
                        err_cnt++;
                        $display("%0t: out_kind expected %0d got %0d", $time, want.kind,
                                 got.kind);
                    end
                    if (got.last !== want.last) begin
                        err_cnt++;
                        $display("%0t: is_last expected %b got %b", $time, want.last, got.last);
                    end
                    if (got.trunc !== want.trunc) begin
                        err_cnt++;
                        $display("%0t: truncated expected %b got %b", $time, want.trunc,
                                 got.trunc);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $time, out_beats_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side back-pressure
    always @(negedge i_clk) begin
        int g;
        if (stall_left > 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else begin
            g = idle_len();
            i_out_ready = (g == 0);
            if (g > 0) stall_left = g - 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic push_byte(input logic [7:0] b);
        int g;
        g = idle_len();
        if (g > 0) begin
            i_in_valid  = 1'b0;
            i_data_byte = 8'($urandom_range(0, 255));
            repeat (g) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (out_beats_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic play_command(input int len, input bit abort);
        int k;
        push_byte(esc_reg);
        push_byte(start_reg);
        for (k = 0; k < len; k++) push_byte(body_byte());
        if (abort) push_byte($urandom_range(0, 1) ? ecf_pkg::CODE_CR : ecf_pkg::CODE_LF);
        else push_byte(end_reg);
    endtask

    task automatic play_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            play_command(cmd_size(), 1'b0);
        end else if (r < 55) begin
            play_command($urandom_range(0, 6), 1'b1);
        end else if (r < 70) begin
            push_byte(esc_reg);
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int i;
        int p;
        int goal;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = 8'h00;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ecf_pkg::CFG_ESC;
        i_cfg_data  = 8'h00;
        flt_mode    = M_IDLE;
        cmd_len     = 0;
        cmd_ovf     = 1'b0;
        esc_reg     = ecf_pkg::ESC_RESET;
        start_reg   = ecf_pkg::START_RESET;
        end_reg     = ecf_pkg::END_RESET;
        row_typed   = 1'b0;
        row_has_res = 1'b0;
        row_res     = NO_RES;
        quiet       = 1'b0;
        stall_left  = 0;
        err_cnt     = 0;
        sent_cnt    = 0;
        cycles      = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < 25; i++) begin
            row_typed   = dir_tbl[i].typed;
            row_has_res = dir_tbl[i].has_res;
            row_res     = dir_tbl[i].res;
            push_byte(dir_tbl[i].data);
        end
        row_typed = 1'b0;

        // store exactly full, then overflow into a truncated command
        play_command(DEPTH, 1'b0);
        play_command(DEPTH + 5, 1'b0);

        for (p = 0; p < 6; p++) begin
            if (p > 0) begin
                // line end brings the filter back to idle in every mode
                push_byte(ecf_pkg::CODE_LF);
                wait_drain();
                if (p == 4) begin
                    ph_esc[p]   = 8'($urandom_range(0, 255));
                    ph_start[p] = 8'($urandom_range(0, 255));
                    ph_end[p]   = 8'($urandom_range(0, 255));
                    write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
                end
                write_reg(ecf_pkg::CFG_ESC, ph_esc[p]);
                write_reg(ecf_pkg::CFG_START, ph_start[p]);
                write_reg(ecf_pkg::CFG_END, ph_end[p]);
            end
            goal = sent_cnt + ph_items[p];
            while (sent_cnt < goal) begin
                if ($urandom_range(0, 19) == 0) quiet = !quiet;
                if ($urandom_range(0, 29) == 0) wait_drain();
                play_sequence();
            end
        end

        wait_drain();
        repeat (10) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
